// ----- rtl/sms_pkg.sv -----
// ============================================================================
// sms_pkg
// Shared types and constants of the sorted multiset statistics block.
// ============================================================================
package sms_pkg;

    // Store geometry and field widths
    localparam int CAPACITY   = 64;
    localparam int ADDR_W     = 6;
    localparam int VALUE_BITS = 16;
    localparam int CNT_W      = 7;
    localparam int SUM_W      = 22;
    localparam int SQR_W      = 32;
    localparam int SQ_W       = 37;
    localparam int PROD_W     = 44;
    localparam int DEN_W      = 13;
    localparam int AVG_W      = 32;
    localparam int MED_W      = 17;
    localparam int VAR_W      = 38;
    localparam int STD_W      = 31;

    // Shared divide / square-root unit
    localparam int DIVD_W     = 50;
    localparam int RAD_W      = 62;
    localparam int REM_W      = 34;
    localparam int STEP_W     = 6;
    localparam int DIV_STEPS  = 50;
    localparam int SQRT_STEPS = 31;

    // Operation codes of an input item
    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_EMPTY     = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_EDIT,
        S_STAT,
        S_MUL,
        S_NUM,
        S_DIV_MEAN,
        S_VAR_GO,
        S_DIV_VAR,
        S_SQRT_GO,
        S_SQRT,
        S_DONE
    } t_state;

    typedef enum logic {
        DU_DIV,
        DU_SQRT
    } t_du_mode;

    typedef struct packed {
        logic     start;
        t_du_mode mode;
    } t_du_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_du_stat;

endpackage

// ----- rtl/sms_channels.sv -----
// ============================================================================
// sms_channels
// Valid/ready channels for input items and result items.
// ============================================================================
interface sms_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  operation;
    logic signed [sms_pkg::VALUE_BITS-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface sms_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            status;
    logic [sms_pkg::CNT_W-1:0]             count;
    logic signed [sms_pkg::VALUE_BITS-1:0] minimum;
    logic signed [sms_pkg::VALUE_BITS-1:0] maximum;
    logic [sms_pkg::VALUE_BITS-1:0]        spread;
    logic signed [sms_pkg::SUM_W-1:0]      total;
    logic signed [sms_pkg::AVG_W-1:0]      average;
    logic signed [sms_pkg::MED_W-1:0]      median_doubled;
    logic signed [sms_pkg::VALUE_BITS-1:0] mode_value;
    logic [sms_pkg::CNT_W-1:0]             mode_run;
    logic [sms_pkg::VAR_W-1:0]             spread_variance;
    logic [sms_pkg::STD_W-1:0]             std_deviation;

    modport source (
        output valid, output status, output count, output minimum, output maximum,
        output spread, output total, output average, output median_doubled,
        output mode_value, output mode_run, output spread_variance,
        output std_deviation, input ready
    );
    modport sink (
        input valid, input status, input count, input minimum, input maximum,
        input spread, input total, input average, input median_doubled,
        input mode_value, input mode_run, input spread_variance,
        input std_deviation, output ready
    );
endinterface

// ----- rtl/sms_ram.sv -----
// ============================================================================
// sms_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module sms_ram #(
    parameter int WIDTH = sms_pkg::VALUE_BITS,
    parameter int DEPTH = sms_pkg::CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/sms_divsqrt.sv -----
// ============================================================================
// sms_divsqrt
// Shared shift-and-subtract unit: restoring division one quotient bit per
// cycle, or integer square root one root bit per cycle.
// ============================================================================
module sms_divsqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sms_pkg::t_du_ctrl              i_ctrl,
    input  logic [sms_pkg::DIVD_W-1:0]     i_dividend,
    input  logic [sms_pkg::DEN_W-1:0]      i_divisor,
    input  logic [sms_pkg::RAD_W-1:0]      i_radicand,
    output sms_pkg::t_du_stat              o_stat,
    output logic [sms_pkg::DIVD_W-1:0]     o_result
);

    logic [sms_pkg::RAD_W-1:0]  r_a;
    logic [sms_pkg::REM_W-1:0]  r_rem;
    logic [sms_pkg::DIVD_W-1:0] r_q;
    logic [sms_pkg::DEN_W-1:0]  r_d;
    logic [sms_pkg::STEP_W-1:0] r_steps;
    sms_pkg::t_du_mode          r_mode;
    logic                       r_busy;
    logic                       r_done;

    logic [sms_pkg::REM_W-1:0]  w_rem_sh;
    logic [sms_pkg::REM_W-1:0]  w_trial;
    logic [sms_pkg::REM_W:0]    w_diff;
    logic                       w_ge;

    // One step: shift in the next digit, trial subtract.
    always_comb begin
        if (r_mode == sms_pkg::DU_DIV) begin
            w_rem_sh = {r_rem[sms_pkg::REM_W-2:0], r_a[sms_pkg::RAD_W-1]};
            w_trial  = sms_pkg::REM_W'(r_d);
        end else begin
            w_rem_sh = {r_rem[sms_pkg::REM_W-3:0], r_a[sms_pkg::RAD_W-1:sms_pkg::RAD_W-2]};
            w_trial  = {r_q[sms_pkg::REM_W-3:0], 2'b01};
        end
        w_diff = {1'b0, w_rem_sh} - {1'b0, w_trial};
        w_ge   = ~w_diff[sms_pkg::REM_W];
    end

    // Control: busy while steps remain, done pulses after the last step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_ctrl.start && r_busy && (r_steps == sms_pkg::STEP_W'(1));
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_steps == sms_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_mode <= i_ctrl.mode;
            r_d    <= i_divisor;
            r_rem  <= '0;
            r_q    <= '0;
            if (i_ctrl.mode == sms_pkg::DU_DIV) begin
                r_a     <= {i_dividend, {(sms_pkg::RAD_W - sms_pkg::DIVD_W){1'b0}}};
                r_steps <= sms_pkg::STEP_W'(sms_pkg::DIV_STEPS);
            end else begin
                r_a     <= i_radicand;
                r_steps <= sms_pkg::STEP_W'(sms_pkg::SQRT_STEPS);
            end
        end else if (r_busy) begin
            r_a     <= (r_mode == sms_pkg::DU_DIV) ? (r_a << 1) : (r_a << 2);
            r_rem   <= w_ge ? w_diff[sms_pkg::REM_W-1:0] : w_rem_sh;
            r_q     <= {r_q[sms_pkg::DIVD_W-2:0], w_ge};
            r_steps <= r_steps - sms_pkg::STEP_W'(1);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_q;

endmodule

// ----- rtl/sorted_multiset_statistics.sv -----
// ============================================================================
// sorted_multiset_statistics
// Sorted multiset of signed values in a RAM with running statistics.
// ============================================================================
// An item that changes the store runs an edit pass and a statistics pass over
// the store RAM, then the mean and variance divisions and the square root; a
// removal of a value not held, or one that empties the store, ends after the edit
// pass, and an item refused for a full or empty store ends at the start check.
// One item at a time; a finished result waits in the output register while the
// next item is taken. Passes take one entry per cycle; the divide unit one bit.
// Reset (synchronous, active low) empties the store and zeroes the statistics.
module sorted_multiset_statistics (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sms_in_if.sink    i_in,
    sms_out_if.source o_out
);

    localparam int VB = sms_pkg::VALUE_BITS;

    sms_pkg::t_state  r_state, n_state;
    sms_pkg::t_status r_status;

    logic                             r_op;
    logic signed [VB-1:0]             r_val;
    logic [sms_pkg::CNT_W-1:0]        r_cnt;
    logic [sms_pkg::CNT_W-1:0]        r_idx;
    logic                             r_pv;
    logic [sms_pkg::CNT_W-1:0]        r_pidx;
    logic                             r_hit;
    logic signed [VB-1:0]             r_carry;

    logic signed [sms_pkg::SUM_W-1:0] r_acc_s;
    logic [sms_pkg::SQR_W-1:0]        r_sqr;
    logic                             r_sq_pv;
    logic [sms_pkg::SQ_W-1:0]         r_acc_sq;
    logic signed [VB-1:0]             r_prev;
    logic [sms_pkg::CNT_W-1:0]        r_run_cur;
    logic signed [VB-1:0]             r_lo;
    logic signed [VB-1:0]             r_hi;
    logic [sms_pkg::PROD_W-1:0]       r_nsq;
    logic [sms_pkg::PROD_W-1:0]       r_ss;
    logic [sms_pkg::PROD_W-1:0]       r_num;
    logic [sms_pkg::DEN_W-1:0]        r_den;
    logic [sms_pkg::SUM_W-1:0]        r_mag;

    // Held statistics
    logic signed [VB-1:0]             r_min;
    logic signed [VB-1:0]             r_max;
    logic [VB-1:0]                    r_spread;
    logic signed [sms_pkg::SUM_W-1:0] r_total;
    logic [sms_pkg::AVG_W-1:0]        r_avg;
    logic signed [sms_pkg::MED_W-1:0] r_med2;
    logic signed [VB-1:0]             r_mode;
    logic [sms_pkg::CNT_W-1:0]        r_run;
    logic [sms_pkg::VAR_W-1:0]        r_var;
    logic [sms_pkg::STD_W-1:0]        r_std;

    // Output register
    logic                             r_out_valid;
    sms_pkg::t_status                 r_o_status;
    logic [sms_pkg::CNT_W-1:0]        r_o_count;
    logic signed [VB-1:0]             r_o_min;
    logic signed [VB-1:0]             r_o_max;
    logic [VB-1:0]                    r_o_spread;
    logic signed [sms_pkg::SUM_W-1:0] r_o_total;
    logic [sms_pkg::AVG_W-1:0]        r_o_avg;
    logic signed [sms_pkg::MED_W-1:0] r_o_med2;
    logic signed [VB-1:0]             r_o_mode;
    logic [sms_pkg::CNT_W-1:0]        r_o_run;
    logic [sms_pkg::VAR_W-1:0]        r_o_var;
    logic [sms_pkg::STD_W-1:0]        r_o_std;

    logic                             w_ram_we;
    logic [sms_pkg::ADDR_W-1:0]       w_ram_waddr;
    logic [VB-1:0]                    w_ram_wdata;
    logic [VB-1:0]                    w_ram_rdata;
    logic signed [VB-1:0]             w_x;
    logic signed [sms_pkg::SQR_W-1:0] w_sq;
    logic                             w_pass_end;
    logic [sms_pkg::CNT_W-1:0]        w_run_new;
    logic signed [sms_pkg::PROD_W-1:0] w_ss;
    logic [sms_pkg::AVG_W-1:0]        w_q32;
    logic                             w_in_xfer;
    logic                             w_slot_free;

    sms_pkg::t_du_ctrl                w_du_ctrl;
    sms_pkg::t_du_stat                w_du_stat;
    logic [sms_pkg::DIVD_W-1:0]       w_du_dividend;
    logic [sms_pkg::DEN_W-1:0]        w_du_divisor;
    logic [sms_pkg::DIVD_W-1:0]       w_du_result;

    sms_ram #(
        .WIDTH (VB),
        .DEPTH (sms_pkg::CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_idx[sms_pkg::ADDR_W-1:0]),
        .o_rdata (w_ram_rdata)
    );

    sms_divsqrt u_divsqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_du_ctrl),
        .i_dividend (w_du_dividend),
        .i_divisor  (w_du_divisor),
        .i_radicand ({r_var, 24'd0}),
        .o_stat     (w_du_stat),
        .o_result   (w_du_result)
    );

    // Helper terms of the passes.
    assign w_x         = signed'(w_ram_rdata);
    assign w_sq        = w_x * w_x;
    assign w_pass_end  = (r_idx == r_cnt) && !r_pv;
    assign w_run_new   = (r_pidx != '0 && w_x == r_prev) ? r_run_cur + 1'b1
                                                         : sms_pkg::CNT_W'(1);
    assign w_ss        = r_acc_s * r_acc_s;
    assign w_q32       = w_du_result[sms_pkg::AVG_W-1:0];
    assign w_in_xfer   = i_in.valid && i_in.ready;
    assign w_slot_free = !r_out_valid || o_out.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sms_pkg::S_IDLE: begin
                if (w_in_xfer) n_state = sms_pkg::S_START;
            end
            sms_pkg::S_START: begin
                if (r_op == sms_pkg::OP_ADD && r_cnt == sms_pkg::CNT_W'(sms_pkg::CAPACITY))
                    n_state = sms_pkg::S_DONE;
                else if (r_op == sms_pkg::OP_REMOVE && r_cnt == '0)
                    n_state = sms_pkg::S_DONE;
                else
                    n_state = sms_pkg::S_EDIT;
            end
            sms_pkg::S_EDIT: begin
                if (w_pass_end) begin
                    if (r_op == sms_pkg::OP_ADD)
                        n_state = sms_pkg::S_STAT;
                    else if (r_hit && r_cnt != sms_pkg::CNT_W'(1))
                        n_state = sms_pkg::S_STAT;
                    else
                        n_state = sms_pkg::S_DONE;
                end
            end
            sms_pkg::S_STAT: begin
                if (w_pass_end && !r_sq_pv) n_state = sms_pkg::S_MUL;
            end
            sms_pkg::S_MUL:      n_state = sms_pkg::S_NUM;
            sms_pkg::S_NUM:      n_state = sms_pkg::S_DIV_MEAN;
            sms_pkg::S_DIV_MEAN: begin
                if (w_du_stat.done) n_state = sms_pkg::S_VAR_GO;
            end
            sms_pkg::S_VAR_GO:   n_state = sms_pkg::S_DIV_VAR;
            sms_pkg::S_DIV_VAR: begin
                if (w_du_stat.done) n_state = sms_pkg::S_SQRT_GO;
            end
            sms_pkg::S_SQRT_GO:  n_state = sms_pkg::S_SQRT;
            sms_pkg::S_SQRT: begin
                if (w_du_stat.done) n_state = sms_pkg::S_DONE;
            end
            sms_pkg::S_DONE: begin
                if (w_slot_free) n_state = sms_pkg::S_IDLE;
            end
            default:             n_state = sms_pkg::S_IDLE;
        endcase
    end

    // Control outputs: store writes, divide unit starts, input ready.
    always_comb begin
        w_ram_we      = 1'b0;
        w_ram_waddr   = r_pidx[sms_pkg::ADDR_W-1:0];
        w_ram_wdata   = r_carry;
        w_du_ctrl     = '{start: 1'b0, mode: sms_pkg::DU_DIV};
        w_du_dividend = sms_pkg::DIVD_W'({r_mag, 16'd0});
        w_du_divisor  = sms_pkg::DEN_W'(r_cnt);
        case (r_state)
            sms_pkg::S_EDIT: begin
                if (r_pv) begin
                    if (r_op == sms_pkg::OP_ADD) begin
                        if (r_hit) begin
                            w_ram_we = 1'b1;
                        end else if (w_x > r_val) begin
                            w_ram_we    = 1'b1;
                            w_ram_wdata = r_val;
                        end
                    end else if (r_hit) begin
                        w_ram_we    = 1'b1;
                        w_ram_waddr = r_pidx[sms_pkg::ADDR_W-1:0] - 1'b1;
                        w_ram_wdata = w_x;
                    end
                end else if (w_pass_end && r_op == sms_pkg::OP_ADD) begin
                    // Tail entry of an insertion.
                    w_ram_we    = 1'b1;
                    w_ram_waddr = r_cnt[sms_pkg::ADDR_W-1:0];
                    w_ram_wdata = r_hit ? r_carry : r_val;
                end
            end
            sms_pkg::S_NUM: begin
                w_du_ctrl.start = 1'b1;
            end
            sms_pkg::S_VAR_GO: begin
                w_du_ctrl.start = 1'b1;
                w_du_dividend   = sms_pkg::DIVD_W'({r_num, 8'd0});
                w_du_divisor    = r_den;
            end
            sms_pkg::S_SQRT_GO: begin
                w_du_ctrl = '{start: 1'b1, mode: sms_pkg::DU_SQRT};
            end
            default: begin
            end
        endcase
    end

    assign i_in.ready = (r_state == sms_pkg::S_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sms_pkg::S_IDLE;
            r_cnt       <= '0;
            r_pv        <= 1'b0;
            r_sq_pv     <= 1'b0;
            r_out_valid <= 1'b0;
            r_min       <= '0;
            r_max       <= '0;
            r_spread    <= '0;
            r_total     <= '0;
            r_avg       <= '0;
            r_med2      <= '0;
            r_mode      <= '0;
            r_run       <= '0;
            r_var       <= '0;
            r_std       <= '0;
        end else begin
            r_state <= n_state;
            // A finished result loads the output register; a transfer empties it.
            if (r_state == sms_pkg::S_DONE && w_slot_free)
                r_out_valid <= 1'b1;
            else if (o_out.valid && o_out.ready)
                r_out_valid <= 1'b0;
            case (r_state)
                sms_pkg::S_IDLE: begin
                    r_pv <= 1'b0;
                end
                sms_pkg::S_EDIT, sms_pkg::S_STAT: begin
                    r_pv    <= (r_idx < r_cnt);
                    r_sq_pv <= r_pv && (r_state == sms_pkg::S_STAT);
                    if (r_state == sms_pkg::S_EDIT && w_pass_end) begin
                        if (r_op == sms_pkg::OP_ADD)
                            r_cnt <= r_cnt + 1'b1;
                        else if (r_hit)
                            r_cnt <= r_cnt - 1'b1;
                    end
                    // Statistics of the pass that need only one entry each.
                    if (r_state == sms_pkg::S_STAT && r_pv) begin
                        if (r_pidx == '0) r_min <= w_x;
                        if (r_pidx == r_cnt - 1'b1) r_max <= w_x;
                        if (r_run < w_run_new) begin
                            r_run  <= w_run_new;
                            r_mode <= w_x;
                        end
                    end
                    if (r_state == sms_pkg::S_EDIT && n_state == sms_pkg::S_STAT) begin
                        r_run  <= sms_pkg::CNT_W'(1);
                        r_mode <= '0;
                    end
                end
                sms_pkg::S_MUL: begin
                    r_total  <= r_acc_s;
                    r_spread <= r_max - r_min;
                    r_med2   <= {r_hi[VB-1], r_hi} +
                                (r_cnt[0] ? {r_hi[VB-1], r_hi} : {r_lo[VB-1], r_lo});
                end
                sms_pkg::S_DIV_MEAN: begin
                    if (w_du_stat.done) r_avg <= r_total[sms_pkg::SUM_W-1] ? -w_q32 : w_q32;
                end
                sms_pkg::S_DIV_VAR: begin
                    if (w_du_stat.done) r_var <= w_du_result[sms_pkg::VAR_W-1:0];
                end
                sms_pkg::S_SQRT: begin
                    if (w_du_stat.done) r_std <= w_du_result[sms_pkg::STD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            sms_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    r_op     <= i_in.operation;
                    r_val    <= i_in.value;
                    r_status <= sms_pkg::STS_OK;
                    r_idx    <= '0;
                    r_hit    <= 1'b0;
                end
            end
            sms_pkg::S_START: begin
                if (r_op == sms_pkg::OP_ADD && r_cnt == sms_pkg::CNT_W'(sms_pkg::CAPACITY))
                    r_status <= sms_pkg::STS_FULL;
                else if (r_op == sms_pkg::OP_REMOVE && r_cnt == '0)
                    r_status <= sms_pkg::STS_EMPTY;
            end
            sms_pkg::S_EDIT: begin
                if (r_idx < r_cnt) begin
                    r_pidx <= r_idx;
                    r_idx  <= r_idx + 1'b1;
                end
                // Insertion carries each displaced entry one place up;
                // removal moves each later entry one place down.
                if (r_pv) begin
                    if (r_op == sms_pkg::OP_ADD) begin
                        if (r_hit) begin
                            r_carry <= w_x;
                        end else if (w_x > r_val) begin
                            r_hit   <= 1'b1;
                            r_carry <= w_x;
                        end
                    end else if (!r_hit && w_x == r_val) begin
                        r_hit <= 1'b1;
                    end
                end
                if (w_pass_end) begin
                    if (r_op == sms_pkg::OP_REMOVE && !r_hit)
                        r_status <= sms_pkg::STS_NOT_FOUND;
                    r_idx     <= '0;
                    r_acc_s   <= '0;
                    r_acc_sq  <= '0;
                    r_run_cur <= sms_pkg::CNT_W'(1);
                end
            end
            sms_pkg::S_STAT: begin
                if (r_idx < r_cnt) begin
                    r_pidx <= r_idx;
                    r_idx  <= r_idx + 1'b1;
                end
                if (r_pv) begin
                    r_acc_s   <= r_acc_s + sms_pkg::SUM_W'(w_x);
                    r_sqr     <= unsigned'(w_sq);
                    r_prev    <= w_x;
                    r_run_cur <= w_run_new;
                    if (r_pidx == (r_cnt >> 1)) r_hi <= w_x;
                    if (r_pidx == (r_cnt >> 1) - 1'b1) r_lo <= w_x;
                end
                if (r_sq_pv) r_acc_sq <= r_acc_sq + sms_pkg::SQ_W'(r_sqr);
            end
            sms_pkg::S_MUL: begin
                r_nsq <= sms_pkg::PROD_W'(r_cnt) * sms_pkg::PROD_W'(r_acc_sq);
                r_ss  <= unsigned'(w_ss);
                r_den <= sms_pkg::DEN_W'(r_cnt) * sms_pkg::DEN_W'(r_cnt);
                r_mag <= r_acc_s[sms_pkg::SUM_W-1] ? unsigned'(-r_acc_s) : unsigned'(r_acc_s);
            end
            sms_pkg::S_NUM: begin
                r_num <= r_nsq - r_ss;
            end
            sms_pkg::S_DONE: begin
                if (w_slot_free) begin
                    r_o_status <= r_status;
                    r_o_count  <= r_cnt;
                    r_o_min    <= r_min;
                    r_o_max    <= r_max;
                    r_o_spread <= r_spread;
                    r_o_total  <= r_total;
                    r_o_avg    <= r_avg;
                    r_o_med2   <= r_med2;
                    r_o_mode   <= r_mode;
                    r_o_run    <= r_run;
                    r_o_var    <= r_var;
                    r_o_std    <= r_std;
                end
            end
            default: begin
            end
        endcase
    end

    // Result channel.
    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_o_status;
    assign o_out.count           = r_o_count;
    assign o_out.minimum         = r_o_min;
    assign o_out.maximum         = r_o_max;
    assign o_out.spread          = r_o_spread;
    assign o_out.total           = r_o_total;
    assign o_out.average         = signed'(r_o_avg);
    assign o_out.median_doubled  = r_o_med2;
    assign o_out.mode_value      = r_o_mode;
    assign o_out.mode_run        = r_o_run;
    assign o_out.spread_variance = r_o_var;
    assign o_out.std_deviation   = r_o_std;

    // The fill count never passes the store size.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= sms_pkg::CNT_W'(sms_pkg::CAPACITY))
        else $error("store fill count above capacity");

    // A full-store result reports a full count.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == sms_pkg::STS_FULL)
        |-> o_out.count == sms_pkg::CNT_W'(sms_pkg::CAPACITY))
        else $error("full status with a count below capacity");

    // An empty-store result reports a zero count.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == sms_pkg::STS_EMPTY) |-> o_out.count == '0)
        else $error("empty status with a nonzero count");

    // The shared unit finishes only while the sequencer waits for it.
    a_du_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_du_stat.done |-> (r_state == sms_pkg::S_DIV_MEAN ||
                            r_state == sms_pkg::S_DIV_VAR ||
                            r_state == sms_pkg::S_SQRT))
        else $error("divide unit finished outside a wait state");

    // The shared unit is never restarted while it is busy.
    a_du_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_du_ctrl.start |-> !w_du_stat.busy)
        else $error("divide unit started while busy");

endmodule
